// ===== rtl/ibm_pkg.sv =====
`default_nettype none
package ibm_pkg;

    localparam int DEF_MAX_GROUPS    = 16;
    localparam int DEF_MAX_PER_GROUP = 8192;
    localparam int DEF_WORD_BITS     = 32;

    localparam int EPG_W      = 14;
    localparam int NG_W       = 5;
    localparam int RSV_W      = 13;
    localparam int NUM_W      = 18;
    localparam int CNT_W      = 14;
    localparam int TOT_W      = 18;
    localparam int CMD_W      = 2;
    localparam int HINT_W     = 4;
    localparam int STAT_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;
    localparam int POS_W      = 6;
    localparam int IN_W       = 24;
    localparam int OUT_W      = 40;

    localparam logic [EPG_W-1:0] EPG_RST = 14'd8192;
    localparam logic [NG_W-1:0]  NG_RST  = 5'd16;
    localparam logic [RSV_W-1:0] RSV_RST = 13'd11;

    localparam logic [CNT_W-1:0] CNT_MAX   = '1;
    localparam logic [TOT_W-1:0] TOTAL_MAX = '1;

    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_INIT  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOT_ALLOC = 2'd2;
    localparam logic [STAT_W-1:0] STAT_RANGE    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_EPG = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NG  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RSV = 2'd2;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] pos;
    } ibm_find_t;

endpackage
`default_nettype wire

// ===== rtl/ibm_ram.sv =====
`default_nettype none
module ibm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ibm_find.sv =====
`default_nettype none
module ibm_find
    import ibm_pkg::*;
#(
    parameter int WORD_BITS = DEF_WORD_BITS
) (
    input  wire logic [WORD_BITS-1:0] word,
    input  wire logic [EPG_W-1:0]     word_idx,
    input  wire logic [EPG_W-1:0]     lo,
    input  wire logic [EPG_W-1:0]     epg,
    output ibm_find_t                 res
);

    localparam int BW = $clog2(WORD_BITS);

    // lowest clear bit whose index lies in [lo, epg)
    always_comb
    begin
        logic [EPG_W:0] idx;
        res = '0;
        for (int k = WORD_BITS - 1; k >= 0; k--)
        begin
            idx = ((EPG_W+1)'(word_idx) << BW) + (EPG_W+1)'(k);
            if (!word[k] && idx >= (EPG_W+1)'(lo) && idx < (EPG_W+1)'(epg))
            begin
                res.found = 1'b1;
                res.pos   = POS_W'(k);
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/inode_bitmap_allocator.sv =====
// Inode bitmap allocator, first fit with a group hint.
// Input stream (s_axis): one request per transfer: allocate, free, init or no-op.
// Output stream (m_axis): exactly one result per request, in order.
// Config port: cfg_we/cfg_addr/cfg_wdata, write only while the block is idle.
// Bitmap lives in one RAM of MAX_GROUPS * MAX_PER_GROUP/WORD_BITS words; one
// compare unit checks one word per cycle; the RAM read data is registered.
// Per request:
//   allocate: the hinted group is scanned first, then the other groups in order;
//     a group whose count is zero is skipped without a scan, and the words of a
//     scanned group are read one after another until a clear bit is found.
//   free: the group is found by repeated subtraction of the group size.
//   init: one RAM word cleared per cycle over the whole RAM, then the counts
//     and the total are loaded.
//   no-op: no change; only a result is returned.
// After reset the same clearing pass runs; s_axis_tready
// stays low until it ends. Counts are zero until the first init.
// One result is held in the output register; a new request is taken while it
// waits, and the block stalls at the end of that request until m_axis_tready.
`default_nettype none
module inode_bitmap_allocator
    import ibm_pkg::*;
#(
    parameter int MAX_GROUPS    = DEF_MAX_GROUPS,
    parameter int MAX_PER_GROUP = DEF_MAX_PER_GROUP,
    parameter int WORD_BITS     = DEF_WORD_BITS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_W-1:0]       s_axis_tdata,  // command, group_hint, inode_number
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic      [OUT_W-1:0]      m_axis_tdata,  // allocated_number, status, free_total
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int WPG   = (MAX_PER_GROUP + WORD_BITS - 1) / WORD_BITS;
    localparam int DEPTH = MAX_GROUPS * WPG;
    localparam int AW    = $clog2(DEPTH);
    localparam int BW    = $clog2(WORD_BITS);
    localparam int GW    = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int GCW   = $clog2(MAX_GROUPS + 2);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_INIT_CNT, ST_ALLOC_GRP, ST_SCAN, ST_SET,
        ST_DIV, ST_FREE_CHK, ST_DONE
    } state_t;

    state_t                state_reg, state_next;
    logic [AW-1:0]         clr_addr_reg, clr_addr_next;
    logic                  init_pend_reg, init_pend_next;
    logic [EPG_W-1:0]      epg_cfg_reg;
    logic [NG_W-1:0]       ng_cfg_reg;
    logic [RSV_W-1:0]      rsv_reg;
    logic [CNT_W-1:0]      cnt_reg [MAX_GROUPS];
    logic [CNT_W-1:0]      cnt_next [MAX_GROUPS];
    logic [TOT_W-1:0]      total_reg, total_next;
    logic [HINT_W-1:0]     hint_reg, hint_next;
    logic [GCW-1:0]        g_reg, g_next;
    logic                  phase_reg, phase_next;
    logic [EPG_W-1:0]      wptr_reg, wptr_next;
    logic [EPG_W-1:0]      chk_reg, chk_next;
    logic                  chk_vld_reg, chk_vld_next;
    logic [EPG_W-1:0]      lo_reg, lo_next;
    logic [WORD_BITS-1:0]  set_word_reg, set_word_next;
    logic [WORD_BITS-1:0]  set_mask_reg, set_mask_next;
    logic [AW-1:0]         set_addr_reg, set_addr_next;
    logic [EPG_W:0]        idx_reg, idx_next;
    logic [NUM_W-1:0]      rem_reg, rem_next;
    logic [NUM_W-1:0]      res_num_reg, res_num_next;
    logic [STAT_W-1:0]     res_stat_reg, res_stat_next;
    logic                  out_valid_reg, out_valid_next;
    logic [NUM_W-1:0]      out_num_reg, out_num_next;
    logic [STAT_W-1:0]     out_stat_reg, out_stat_next;
    logic [TOT_W-1:0]      out_total_reg, out_total_next;

    logic [CMD_W-1:0]      in_cmd;
    logic [HINT_W-1:0]     in_hint;
    logic [NUM_W-1:0]      in_num;
    logic [EPG_W-1:0]      epg;
    logic [NG_W-1:0]       ng;
    logic [GW-1:0]         g_idx;
    logic [CNT_W-1:0]      cnt_g;
    logic [EPG_W-1:0]      grp_start;
    logic [EPG_W-1:0]      last_w;
    logic [GCW-1:0]        g_adv;
    logic [EPG_W-1:0]      rem_word;
    logic [BW-1:0]         rem_bit;
    logic                  ram_we, ram_re;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    logic [WORD_BITS-1:0]  ram_wdata, ram_rdata;
    ibm_find_t             find;

    assign in_cmd  = s_axis_tdata[1:0];
    assign in_hint = s_axis_tdata[5:2];
    assign in_num  = s_axis_tdata[23:6];

    assign epg = (int'(epg_cfg_reg) > MAX_PER_GROUP) ? EPG_W'(MAX_PER_GROUP) : epg_cfg_reg;
    assign ng  = (int'(ng_cfg_reg) > MAX_GROUPS) ? NG_W'(MAX_GROUPS) : ng_cfg_reg;

    assign g_idx     = g_reg[GW-1:0];
    assign cnt_g     = cnt_reg[g_idx];
    assign grp_start = (g_reg == '0) ? EPG_W'(rsv_reg) : '0;
    assign last_w    = (epg - EPG_W'(1)) >> BW;
    assign rem_word  = EPG_W'(rem_reg >> BW);
    assign rem_bit   = rem_reg[BW-1:0];

    always_comb
    begin
        logic [GCW-1:0] gn;
        gn = phase_reg ? '0 : g_reg + GCW'(1);
        if (int'(gn) == int'(hint_reg))
        begin
            gn = gn + GCW'(1);
        end
        g_adv = gn;
    end

    ibm_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ibm_find #(
        .WORD_BITS (WORD_BITS)
    ) u_find (
        .word     (ram_rdata),
        .word_idx (chk_reg),
        .lo       (lo_reg),
        .epg      (epg),
        .res      (find)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_total_reg, out_stat_reg, out_num_reg};

    always_comb
    begin
        logic [NUM_W:0]  span;
        logic [EPG_W-1:0] rsv_cut;
        logic [NUM_W:0]  sum;
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        init_pend_next = init_pend_reg;
        cnt_next       = cnt_reg;
        total_next     = total_reg;
        hint_next      = hint_reg;
        g_next         = g_reg;
        phase_next     = phase_reg;
        wptr_next      = wptr_reg;
        chk_next       = chk_reg;
        chk_vld_next   = chk_vld_reg;
        lo_next        = lo_reg;
        set_word_next  = set_word_reg;
        set_mask_next  = set_mask_reg;
        set_addr_next  = set_addr_reg;
        idx_next       = idx_reg;
        rem_next       = rem_reg;
        res_num_next   = res_num_reg;
        res_stat_next  = res_stat_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_num_next   = out_num_reg;
        out_stat_next  = out_stat_reg;
        out_total_next = out_total_reg;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = '0;
        span      = (NUM_W+1)'(ng) * (NUM_W+1)'(epg);
        rsv_cut   = (EPG_W'(rsv_reg) < epg) ? EPG_W'(rsv_reg) : epg;
        sum       = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (int'(clr_addr_reg) == DEPTH - 1)
                begin
                    state_next = init_pend_reg ? ST_INIT_CNT : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    hint_next     = in_hint;
                    res_num_next  = '0;
                    res_stat_next = STAT_OK;
                    state_next    = ST_DONE;
                    case (in_cmd)
                        CMD_ALLOC:
                        begin
                            if (total_reg == '0)
                            begin
                                res_stat_next = STAT_FULL;
                            end
                            else
                            begin
                                state_next = ST_ALLOC_GRP;
                                if (NG_W'(in_hint) < ng)
                                begin
                                    g_next     = GCW'(in_hint);
                                    phase_next = 1'b1;
                                end
                                else
                                begin
                                    g_next     = '0;
                                    phase_next = 1'b0;
                                end
                            end
                        end
                        CMD_FREE:
                        begin
                            if (in_num == '0 || epg == '0 || (NUM_W+1)'(in_num) > span)
                            begin
                                res_stat_next = STAT_RANGE;
                            end
                            else
                            begin
                                rem_next   = in_num - NUM_W'(1);
                                g_next     = '0;
                                state_next = ST_DIV;
                            end
                        end
                        CMD_INIT:
                        begin
                            init_pend_next = 1'b1;
                            clr_addr_next  = '0;
                            state_next     = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_INIT_CNT:
            begin
                for (int g = 0; g < MAX_GROUPS; g++)
                begin
                    cnt_next[g] = (g < int'(ng)) ? CNT_W'(epg) : '0;
                end
                if (ng != '0)
                begin
                    cnt_next[0] = CNT_W'(epg - rsv_cut);
                    sum = span - (NUM_W+1)'(rsv_cut);
                end
                total_next     = (sum > (NUM_W+1)'(TOTAL_MAX)) ? TOTAL_MAX : TOT_W'(sum);
                init_pend_next = 1'b0;
                state_next     = ST_DONE;
            end
            ST_ALLOC_GRP:
            begin
                chk_vld_next = 1'b0;
                if (g_reg >= GCW'(ng))
                begin
                    res_stat_next = STAT_FULL;
                    state_next    = ST_DONE;
                end
                else if (cnt_g == '0 || grp_start >= epg)
                begin
                    g_next     = g_adv;
                    phase_next = 1'b0;
                end
                else
                begin
                    wptr_next  = grp_start >> BW;
                    lo_next    = grp_start;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                ram_re    = (wptr_reg <= last_w);
                ram_raddr = AW'(int'(g_idx) * WPG + int'(wptr_reg));
                if (chk_vld_reg && find.found)
                begin
                    set_mask_next = WORD_BITS'(1) << find.pos;
                    set_word_next = ram_rdata | (WORD_BITS'(1) << find.pos);
                    set_addr_next = AW'(int'(g_idx) * WPG + int'(chk_reg));
                    idx_next      = ((EPG_W+1)'(chk_reg) << BW) + (EPG_W+1)'(find.pos);
                    state_next    = ST_SET;
                end
                else if (chk_vld_reg && chk_reg == last_w)
                begin
                    g_next     = g_adv;
                    phase_next = 1'b0;
                    state_next = ST_ALLOC_GRP;
                end
                else if (ram_re)
                begin
                    wptr_next    = wptr_reg + EPG_W'(1);
                    chk_next     = wptr_reg;
                    chk_vld_next = 1'b1;
                end
                else
                begin
                    chk_vld_next = 1'b0;
                end
            end
            ST_SET:
            begin
                ram_we         = 1'b1;
                ram_waddr      = set_addr_reg;
                ram_wdata      = set_word_reg;
                cnt_next[g_idx] = cnt_g - CNT_W'(1);
                total_next     = total_reg - TOT_W'(1);
                res_num_next   = NUM_W'((NUM_W+1)'(g_reg) * (NUM_W+1)'(epg)
                                 + (NUM_W+1)'(idx_reg) + (NUM_W+1)'(1));
                state_next     = ST_DONE;
            end
            ST_DIV:
            begin
                if (rem_reg >= NUM_W'(epg))
                begin
                    rem_next = rem_reg - NUM_W'(epg);
                    g_next   = g_reg + GCW'(1);
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = AW'(int'(g_idx) * WPG + int'(rem_word));
                    state_next = ST_FREE_CHK;
                end
            end
            ST_FREE_CHK:
            begin
                state_next = ST_DONE;
                if (!ram_rdata[rem_bit])
                begin
                    res_stat_next = STAT_NOT_ALLOC;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(int'(g_idx) * WPG + int'(rem_word));
                    ram_wdata = ram_rdata & ~(WORD_BITS'(1) << rem_bit);
                    if (cnt_g != CNT_MAX)
                    begin
                        cnt_next[g_idx] = cnt_g + CNT_W'(1);
                    end
                    if (total_reg != TOTAL_MAX)
                    begin
                        total_next = total_reg + TOT_W'(1);
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_num_next   = res_num_reg;
                    out_stat_next  = res_stat_reg;
                    out_total_next = total_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            init_pend_reg <= 1'b0;
            epg_cfg_reg   <= EPG_RST;
            ng_cfg_reg    <= NG_RST;
            rsv_reg       <= RSV_RST;
            for (int g = 0; g < MAX_GROUPS; g++)
            begin
                cnt_reg[g] <= '0;
            end
            total_reg     <= '0;
            hint_reg      <= '0;
            g_reg         <= '0;
            phase_reg     <= 1'b0;
            wptr_reg      <= '0;
            chk_reg       <= '0;
            chk_vld_reg   <= 1'b0;
            lo_reg        <= '0;
            set_word_reg  <= '0;
            set_mask_reg  <= '0;
            set_addr_reg  <= '0;
            idx_reg       <= '0;
            rem_reg       <= '0;
            res_num_reg   <= '0;
            res_stat_reg  <= STAT_OK;
            out_valid_reg <= 1'b0;
            out_num_reg   <= '0;
            out_stat_reg  <= STAT_OK;
            out_total_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            init_pend_reg <= init_pend_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_EPG: epg_cfg_reg <= cfg_wdata;
                    REG_NG:  ng_cfg_reg  <= cfg_wdata[NG_W-1:0];
                    REG_RSV: rsv_reg     <= cfg_wdata[RSV_W-1:0];
                    default: ;
                endcase
            end
            cnt_reg       <= cnt_next;
            total_reg     <= total_next;
            hint_reg      <= hint_next;
            g_reg         <= g_next;
            phase_reg     <= phase_next;
            wptr_reg      <= wptr_next;
            chk_reg       <= chk_next;
            chk_vld_reg   <= chk_vld_next;
            lo_reg        <= lo_next;
            set_word_reg  <= set_word_next;
            set_mask_reg  <= set_mask_next;
            set_addr_reg  <= set_addr_next;
            idx_reg       <= idx_next;
            rem_reg       <= rem_next;
            res_num_reg   <= res_num_next;
            res_stat_reg  <= res_stat_next;
            out_valid_reg <= out_valid_next;
            out_num_reg   <= out_num_next;
            out_stat_reg  <= out_stat_next;
            out_total_reg <= out_total_next;
        end
    end

    a_set_one_bit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SET |-> $onehot(set_mask_reg))
        else $error("allocation sets other than one bit");

    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !s_axis_tready && ram_we)
        else $error("request taken during clearing pass");

    a_full_no_number: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stat_reg != STAT_OK |-> out_num_reg == '0)
        else $error("number returned with failing status");

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
    import ibm_pkg::*;

    typedef struct packed {
        logic [NUM_W-1:0]  num;
        logic [HINT_W-1:0] hint;
        logic [CMD_W-1:0]  cmd;
    } request_t;

    typedef struct packed {
        logic [1:0]        pad;
        logic [TOT_W-1:0]  free_total;
        logic [STAT_W-1:0] status;
        logic [NUM_W-1:0]  alloc_num;
    } reply_t;

    localparam int GROUPS  = 16;
    localparam int PER_GRP = 8192;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_W-1:0]      m_axis_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr = REG_EPG;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    inode_bitmap_allocator uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always #5 clk = ~clk;

    // shadow allocator state
    bit              used_map [0:GROUPS*PER_GRP-1];
    int unsigned     grp_free [GROUPS];
    int unsigned     tot_free;
    int unsigned     epg_reg, ng_reg, rsv_reg;

    request_t        pending_reqs[$];
    reply_t          expected_replies[$];
    int unsigned     live_inodes[$];
    int              errors = 0;
    bit              calm = 1'b0;
    bit              in_fire = 1'b0;
    int              src_gap = 0;
    int              dst_gap = 0;
    int              items_sent = 0;

    function automatic bit grab_in_group(int unsigned g, output int unsigned idx);
        int unsigned lim;
        int unsigned b;
        lim = (epg_reg > PER_GRP) ? PER_GRP : epg_reg;
        b = (g == 0) ? rsv_reg : 0;
        if (g >= GROUPS || grp_free[g] < 1)
            return 0;
        for (int unsigned i = b; i < lim; i++)
        begin
            if (!used_map[g*PER_GRP + i])
            begin
                used_map[g*PER_GRP + i] = 1'b1;
                grp_free[g]--;
                tot_free--;
                idx = i;
                return 1;
            end
        end
        return 0;
    endfunction

    function automatic reply_t predict_reply(request_t rq);
        reply_t      r;
        int unsigned epg, ng, idx, g, z, i, c, sum;
        bit          found;
        epg = (epg_reg > PER_GRP) ? PER_GRP : epg_reg;
        ng = (ng_reg > GROUPS) ? GROUPS : ng_reg;
        r = '0;
        found = 0;
        idx = 0;
        g = 0;
        case (rq.cmd)
            CMD_ALLOC:
            begin
                r.status = STAT_FULL;
                if (tot_free >= 1)
                begin
                    if (rq.hint < ng && grab_in_group(rq.hint, idx))
                    begin
                        found = 1;
                        g = rq.hint;
                    end
                    for (int unsigned k = 0; k < ng && !found; k++)
                    begin
                        if (k != rq.hint && grab_in_group(k, idx))
                        begin
                            found = 1;
                            g = k;
                        end
                    end
                end
                if (found)
                begin
                    r.alloc_num = NUM_W'(g*epg + idx + 1);
                    r.status = STAT_OK;
                end
            end
            CMD_FREE:
            begin
                if (rq.num == 0 || epg == 0 || rq.num > ng*epg)
                    r.status = STAT_RANGE;
                else
                begin
                    z = rq.num - 1;
                    g = z / epg;
                    i = z % epg;
                    if (!used_map[g*PER_GRP + i])
                        r.status = STAT_NOT_ALLOC;
                    else
                    begin
                        used_map[g*PER_GRP + i] = 1'b0;
                        if (grp_free[g] < 16383)
                            grp_free[g]++;
                        if (tot_free < 262143)
                            tot_free++;
                        r.status = STAT_OK;
                    end
                end
            end
            CMD_INIT:
            begin
                sum = 0;
                foreach (used_map[k])
                    used_map[k] = 1'b0;
                for (int unsigned k = 0; k < GROUPS; k++)
                begin
                    c = 0;
                    if (k < ng)
                    begin
                        c = epg;
                        if (k == 0)
                            c -= (rsv_reg < epg) ? rsv_reg : epg;
                    end
                    grp_free[k] = c;
                    sum += c;
                end
                tot_free = (sum > 262143) ? 262143 : sum;
            end
            default: ;
        endcase
        r.free_total = TOT_W'(tot_free);
        return r;
    endfunction

    task automatic issue(logic [CMD_W-1:0] cmd, int unsigned hint, int unsigned num);
        request_t rq;
        reply_t   r;
        rq.cmd = cmd;
        rq.hint = HINT_W'(hint);
        rq.num = NUM_W'(num);
        r = predict_reply(rq);
        if (cmd == CMD_ALLOC && r.status == STAT_OK)
            live_inodes.push_back(r.alloc_num);
        if (cmd == CMD_INIT)
            live_inodes.delete();
        pending_reqs.push_back(rq);
        expected_replies.push_back(r);
        items_sent++;
    endtask

    task automatic drain;
        do
            @(posedge clk);
        while (pending_reqs.size() != 0 || s_axis_tvalid || expected_replies.size() != 0);
        repeat (5) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_addr = idx;
        cfg_wdata = CFG_DATA_W'(val);
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_EPG: epg_reg = val & 16'h3FFF;
            REG_NG:  ng_reg = val & 5'h1F;
            default: rsv_reg = val & 13'h1FFF;
        endcase
    endtask

    task automatic setup(int unsigned epg, int unsigned ng, int unsigned rsv);
        drain();
        write_reg(REG_EPG, epg);
        write_reg(REG_NG, ng);
        write_reg(REG_RSV, rsv);
    endtask

    task automatic random_mix(int n, bit do_init);
        int unsigned r, span, k;
        span = ((epg_reg > PER_GRP) ? PER_GRP : epg_reg) *
               ((ng_reg > GROUPS) ? GROUPS : ng_reg);
        if (do_init)
            issue(CMD_INIT, $urandom_range(0, 15), $urandom);
        for (int j = 0; j < n; j++)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                issue(CMD_ALLOC, $urandom_range(0, 15), $urandom);
            else if (r < 80 && live_inodes.size() != 0)
            begin
                k = $urandom_range(0, live_inodes.size() - 1);
                issue(CMD_FREE, $urandom_range(0, 15), live_inodes[k]);
                live_inodes.delete(k);
            end
            else if (r < 88)
                issue(CMD_FREE, $urandom_range(0, 15), $urandom_range(0, span + 2));
            else if (r < 92)
                issue(CMD_FREE, $urandom_range(0, 15), $urandom_range(0, 262143));
            else if (r < 97)
                issue(CMD_NOP, $urandom_range(0, 15), $urandom_range(0, 262143));
            else
                issue(CMD_INIT, $urandom_range(0, 15), $urandom_range(0, 262143));
        end
    endtask

    // source side
    always @(posedge clk)
        in_fire <= s_axis_tvalid && s_axis_tready;

    always @(negedge clk)
    begin
        if (rst_n && (in_fire || !s_axis_tvalid))
        begin
            if (src_gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                src_gap <= src_gap - 1;
            end
            else if (pending_reqs.size() != 0)
            begin
                s_axis_tdata <= pending_reqs.pop_front();
                s_axis_tvalid <= 1'b1;
                if (!calm && $urandom_range(0, 7) == 0)
                    src_gap <= $urandom_range(1, 9);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // sink side
    always @(negedge clk)
    begin
        if (dst_gap > 0)
        begin
            m_axis_tready <= 1'b0;
            dst_gap <= dst_gap - 1;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (!calm && $urandom_range(0, 9) == 0)
                dst_gap <= $urandom_range(1, 9);
        end
    end

    always @(posedge clk)
    begin
        reply_t got, want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (expected_replies.size() == 0)
            begin
                $error("unexpected transfer %h", m_axis_tdata);
                errors++;
            end
            else
            begin
                want = expected_replies.pop_front();
                if (got.alloc_num !== want.alloc_num)
                begin
                    $error("allocated_number expected %0d got %0d", want.alloc_num, got.alloc_num);
                    errors++;
                end
                if (got.status !== want.status)
                begin
                    $error("status expected %0d got %0d", want.status, got.status);
                    errors++;
                end
                if (got.free_total !== want.free_total)
                begin
                    $error("free_total expected %0d got %0d", want.free_total, got.free_total);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        epg_reg = 8192;
        ng_reg = 16;
        rsv_reg = 11;
        tot_free = 0;
        foreach (grp_free[k])
            grp_free[k] = 0;
        foreach (used_map[k])
            used_map[k] = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // before init: counts are zero
        issue(CMD_ALLOC, 0, 0);
        issue(CMD_FREE, 15, 0);
        issue(CMD_FREE, 3, 262143);
        issue(CMD_FREE, 0, 5);
        issue(CMD_NOP, 15, 262143);
        issue(CMD_INIT, 0, 0);
        issue(CMD_ALLOC, 15, 0);
        issue(CMD_ALLOC, 0, 0);
        issue(CMD_FREE, 0, 131072);
        issue(CMD_FREE, 0, 131073);

        setup(32, 2, 0);
        issue(CMD_INIT, 0, 0);
        issue(CMD_ALLOC, 0, 0);
        issue(CMD_ALLOC, 1, 0);
        issue(CMD_ALLOC, 9, 0);
        issue(CMD_FREE, 0, 1);
        issue(CMD_FREE, 0, 1);
        issue(CMD_FREE, 0, 64);
        issue(CMD_FREE, 0, 65);
        random_mix(80, 0);

        setup(32, 3, 40);
        random_mix(90, 1);
        setup(8192, 16, 8191);
        random_mix(60, 1);
        setup(16383, 16, 5);
        random_mix(60, 1);
        setup(64, 4, 11);
        random_mix(100, 1);
        setup(40, 5, 3);
        random_mix(60, 0);
        setup(0, 3, 0);
        random_mix(30, 1);
        setup(100, 0, 2);
        random_mix(30, 1);
        setup(48, 31, 7);
        random_mix(100, 1);
        setup(32, 1, 31);
        random_mix(60, 1);
        while (items_sent < 1150)
        begin
            setup($urandom_range(32, 160), $urandom_range(1, 16), $urandom_range(0, 40));
            if (items_sent > 1000)
                calm = 1'b1;
            random_mix(90, 1);
        end
        drain();
        repeat (300) @(posedge clk);
        if (errors == 0)
            $display("inode_bitmap_allocator test passed");
        else
            $display("inode_bitmap_allocator test failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("inode_bitmap_allocator test failed");
        $finish;
    end

endmodule
